// ----- hdl/sdid_pkg.sv -----
// Shared types and constants for the SD card identification sequencer.
package sdid_pkg;

    // APB register map
    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_RETRY_LIMIT = '0;
    localparam logic [7:0] RETRY_LIMIT_RESET = 8'hFF;

    // Finish status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_FAILED      = 3'd1;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
    localparam logic [2:0] ST_TIMEOUT     = 3'd3;
    localparam logic [2:0] ST_RESP_ERR    = 3'd4;
    localparam logic [2:0] ST_XPORT_ERR   = 3'd5;

    // Card type codes
    localparam logic [2:0] CT_UNKNOWN = 3'd0;
    localparam logic [2:0] CT_SDSC_V1 = 3'd1;
    localparam logic [2:0] CT_SDSC_V2 = 3'd2;
    localparam logic [2:0] CT_SDHC    = 3'd3;
    localparam logic [2:0] CT_SDXC    = 3'd4;

    // Command indexes and arguments
    localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
    localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
    localparam logic [5:0] CMD_SD_OP_COND   = 6'd41;
    localparam logic [5:0] CMD_APP_CMD      = 6'd55;
    localparam logic [5:0] CMD_READ_OCR     = 6'd58;

    localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS      = 32'h4000_0000;
    localparam logic [31:0] ARG_BLOCKLEN = 32'd512;
    localparam logic [7:0]  CHECK_PATTERN = 8'hAA;
    localparam logic [7:0]  R1_IDLE       = 8'h01;
    localparam logic [1:0]  V2_CSD_DUMMY  = 2'd2;

    localparam logic [41:0] SDXC_THRESHOLD = 42'd32000000000;

    typedef struct packed {
        logic        func;
        logic        transport_ok;
        logic [7:0]  r1_byte;
        logic [31:0] resp_word;
        logic [63:0] csd_high;
        logic [63:0] csd_low;
    } t_item;

    typedef struct packed {
        logic        action;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic [1:0]  dummy_before;
        logic        delay_before;
        logic [2:0]  status;
        logic [2:0]  card_type;
        logic [32:0] num_blocks;
        logic [15:0] blk_bytes;
        logic [7:0]  erase_size_log2;
        logic [41:0] capacity_bytes;
    } t_result;

    typedef struct packed {
        logic        ok;
        logic        is_xc;
        logic [32:0] num_blocks;
        logic [15:0] blk_bytes;
        logic [7:0]  erase_size_log2;
        logic [41:0] capacity_bytes;
    } t_csd;

endpackage

// ----- hdl/sdid_ifs.sv -----
// Valid/ready channel interfaces for sequencer input and result items.
interface sdid_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic        transport_ok;
    logic [7:0]  r1_byte;
    logic [31:0] resp_word;
    logic [63:0] csd_high;
    logic [63:0] csd_low;

    modport source(output valid, func, transport_ok, r1_byte, resp_word, csd_high, csd_low,
                   input ready);
    modport sink(input valid, func, transport_ok, r1_byte, resp_word, csd_high, csd_low,
                 output ready);
endinterface

interface sdid_out_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  dummy_before;
    logic        delay_before;
    logic [2:0]  status;
    logic [2:0]  card_type;
    logic [32:0] num_blocks;
    logic [15:0] blk_bytes;
    logic [7:0]  erase_size_log2;
    logic [41:0] capacity_bytes;

    modport source(output valid, action, cmd_index, cmd_arg, dummy_before, delay_before,
                   status, card_type, num_blocks, blk_bytes, erase_size_log2,
                   capacity_bytes, input ready);
    modport sink(input valid, action, cmd_index, cmd_arg, dummy_before, delay_before,
                 status, card_type, num_blocks, blk_bytes, erase_size_log2,
                 capacity_bytes, output ready);
endinterface

// ----- hdl/sdid_cfg.sv -----
// APB configuration register: ACMD41 retry limit.
module sdid_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdid_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [7:0]                    o_retry_limit
);
    logic       s_hit;
    logic [7:0] r_retry_limit;

    assign s_hit  = (paddr[sdid_pkg::PADDR_W-1:2] == sdid_pkg::REG_RETRY_LIMIT);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= sdid_pkg::RETRY_LIMIT_RESET;
        end else if (psel && penable && pwrite && s_hit) begin
            r_retry_limit <= pwdata[7:0];
        end
    end

    assign prdata        = s_hit ? {24'd0, r_retry_limit} : 32'd0;
    assign o_retry_limit = r_retry_limit;
endmodule

// ----- hdl/sdid_csd_dec.sv -----
// CSD decoder for v1 (SDSC) and v2 (SDHC/SDXC) layouts.
module sdid_csd_dec (
    input  logic [63:0]        i_csd_high,
    input  logic [63:0]        i_csd_low,
    input  logic               i_layout_v2,
    output sdid_pkg::t_csd     o_csd
);
    logic [7:0]  s_b0, s_b4, s_b5, s_b6, s_b7, s_b8, s_b9, s_b10;
    logic [22:0] s_v2_blocks_k;   // c_size + 1, in units of 1024 blocks
    logic [41:0] s_v2_cap;
    logic [12:0] s_v1_csize_p1;
    logic [3:0]  s_v1_shift;
    logic [32:0] s_v1_cnt;
    logic [41:0] s_v1_cap;

    assign s_b0  = i_csd_high[63:56];
    assign s_b4  = i_csd_high[31:24];
    assign s_b5  = i_csd_high[23:16];
    assign s_b6  = i_csd_high[15:8];
    assign s_b7  = i_csd_high[7:0];
    assign s_b8  = i_csd_low[63:56];
    assign s_b9  = i_csd_low[55:48];
    assign s_b10 = i_csd_low[47:40];

    assign s_v2_blocks_k = {1'b0, s_b7[5:0], s_b8, s_b9} + 23'd1;
    assign s_v2_cap      = {s_v2_blocks_k, 19'd0};

    assign s_v1_csize_p1 = {1'b0, s_b6[1:0], s_b7, s_b8[7:6]} + 13'd1;
    assign s_v1_shift    = {1'b0, s_b9[1:0], s_b10[7]} + 4'd2;
    assign s_v1_cnt      = {20'd0, s_v1_csize_p1} << s_v1_shift;
    assign s_v1_cap      = {9'd0, s_v1_cnt} << s_b5[3:0];

    always_comb begin
        o_csd.erase_size_log2 = {1'b0, s_b4[7], s_b5[5:0]} + 8'd1;
        if (i_layout_v2) begin
            o_csd.ok             = (s_b0[7:6] == 2'd1);
            o_csd.num_blocks     = {s_v2_blocks_k, 10'd0};
            o_csd.blk_bytes      = 16'd512;
            o_csd.capacity_bytes = s_v2_cap;
            o_csd.is_xc          = (s_v2_cap > sdid_pkg::SDXC_THRESHOLD);
        end else begin
            o_csd.ok             = (s_b0[7:6] == 2'd0);
            o_csd.num_blocks     = s_v1_cnt;
            o_csd.blk_bytes      = 16'd1 << s_b5[3:0];
            o_csd.capacity_bytes = s_v1_cap;
            o_csd.is_xc          = 1'b0;
        end
    end
endmodule

// ----- hdl/sdid_seq.sv -----
// Identification state and next-command logic, one item per enabled cycle.
module sdid_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  sdid_pkg::t_item     i_item,
    input  logic [7:0]          i_retry_limit,
    output logic                o_has_result,
    output sdid_pkg::t_result   o_result
);
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_CMD8   = 3'd1;
    localparam logic [2:0] PH_CMD55  = 3'd2;
    localparam logic [2:0] PH_ACMD41 = 3'd3;
    localparam logic [2:0] PH_CMD16  = 3'd4;
    localparam logic [2:0] PH_CMD58  = 3'd5;
    localparam logic [2:0] PH_CMD9   = 3'd6;

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_retries, n_retries;
    logic       r_path_v2, n_path_v2;
    logic [2:0] r_found, n_found;
    logic [7:0] s_retries_dec;
    sdid_pkg::t_csd s_csd;

    function automatic sdid_pkg::t_result f_cmd(input logic [5:0] idx, input logic [31:0] arg,
                                                input logic [1:0] dummy, input logic dly);
        sdid_pkg::t_result r;
        r              = '0;
        r.cmd_index    = idx;
        r.cmd_arg      = arg;
        r.dummy_before = dummy;
        r.delay_before = dly;
        return r;
    endfunction

    function automatic sdid_pkg::t_result f_fail(input logic [2:0] st, input logic [2:0] ct);
        sdid_pkg::t_result r;
        r           = '0;
        r.action    = 1'b1;
        r.status    = st;
        r.card_type = ct;
        return r;
    endfunction

    sdid_csd_dec u_csd (
        .i_csd_high  (i_item.csd_high),
        .i_csd_low   (i_item.csd_low),
        .i_layout_v2 (r_found == sdid_pkg::CT_SDHC),
        .o_csd       (s_csd)
    );

    assign s_retries_dec = r_retries - 8'd1;

    always_comb begin
        n_phase      = r_phase;
        n_retries    = r_retries;
        n_path_v2    = r_path_v2;
        n_found      = r_found;
        o_has_result = 1'b1;
        o_result     = '0;
        if (!i_item.func) begin
            n_found  = sdid_pkg::CT_UNKNOWN;
            n_phase  = PH_CMD8;
            o_result = f_cmd(sdid_pkg::CMD_SEND_IF_COND, sdid_pkg::ARG_IF_COND, 2'd0, 1'b0);
        end else begin
            case (r_phase)
                PH_CMD8: begin
                    if (!i_item.transport_ok ||
                        (i_item.r1_byte == sdid_pkg::R1_IDLE &&
                         i_item.resp_word[11:8] == 4'd1 &&
                         i_item.resp_word[7:0] == sdid_pkg::CHECK_PATTERN)) begin
                        // failed exchange means v1 card, good echo means v2
                        n_path_v2 = i_item.transport_ok;
                        n_retries = (i_retry_limit == 8'd0) ? 8'd1 : i_retry_limit;
                        n_phase   = PH_CMD55;
                        o_result  = f_cmd(sdid_pkg::CMD_APP_CMD, 32'd0, 2'd0, 1'b0);
                    end else if (i_item.r1_byte != sdid_pkg::R1_IDLE) begin
                        n_phase  = PH_IDLE;
                        o_result = f_fail(sdid_pkg::ST_RESP_ERR, r_found);
                    end else begin
                        n_phase  = PH_IDLE;
                        o_result = f_fail(sdid_pkg::ST_UNSUPPORTED, r_found);
                    end
                end
                PH_CMD55: begin
                    if (!i_item.transport_ok) begin
                        n_phase  = PH_IDLE;
                        o_result = f_fail(sdid_pkg::ST_XPORT_ERR, r_found);
                    end else if (i_item.r1_byte != sdid_pkg::R1_IDLE) begin
                        n_phase  = PH_IDLE;
                        o_result = f_fail(r_path_v2 ? sdid_pkg::ST_UNSUPPORTED
                                                    : sdid_pkg::ST_FAILED, r_found);
                    end else begin
                        n_phase  = PH_ACMD41;
                        o_result = f_cmd(sdid_pkg::CMD_SD_OP_COND,
                                         r_path_v2 ? sdid_pkg::ARG_HCS : 32'd0, 2'd0, 1'b0);
                    end
                end
                PH_ACMD41: begin
                    if (!i_item.transport_ok) begin
                        n_phase  = PH_IDLE;
                        o_result = f_fail(sdid_pkg::ST_XPORT_ERR, r_found);
                    end else if (!i_item.r1_byte[0]) begin
                        if (r_path_v2) begin
                            n_phase  = PH_CMD58;
                            o_result = f_cmd(sdid_pkg::CMD_READ_OCR, 32'd0, 2'd0, 1'b0);
                        end else begin
                            n_found  = sdid_pkg::CT_SDSC_V1;
                            n_phase  = PH_CMD16;
                            o_result = f_cmd(sdid_pkg::CMD_SET_BLOCKLEN,
                                             sdid_pkg::ARG_BLOCKLEN, 2'd0, 1'b0);
                        end
                    end else begin
                        n_retries = s_retries_dec;
                        if (s_retries_dec == 8'd0) begin
                            n_phase  = PH_IDLE;
                            o_result = f_fail(sdid_pkg::ST_TIMEOUT, r_found);
                        end else begin
                            n_phase  = PH_CMD55;
                            o_result = f_cmd(sdid_pkg::CMD_APP_CMD, 32'd0, 2'd0, r_path_v2);
                        end
                    end
                end
                PH_CMD16: begin
                    if (!i_item.transport_ok) begin
                        n_phase  = PH_IDLE;
                        o_result = f_fail(sdid_pkg::ST_XPORT_ERR, r_found);
                    end else if (i_item.r1_byte != 8'd0) begin
                        n_phase  = PH_IDLE;
                        o_result = f_fail(sdid_pkg::ST_RESP_ERR, r_found);
                    end else begin
                        n_phase  = PH_CMD9;
                        o_result = f_cmd(sdid_pkg::CMD_SEND_CSD, 32'd0, 2'd0, 1'b0);
                    end
                end
                PH_CMD58: begin
                    if (!i_item.transport_ok) begin
                        n_phase  = PH_IDLE;
                        o_result = f_fail(sdid_pkg::ST_XPORT_ERR, r_found);
                    end else if (i_item.r1_byte[7]) begin
                        n_phase  = PH_IDLE;
                        o_result = f_fail(sdid_pkg::ST_UNSUPPORTED, r_found);
                    end else begin
                        // CCS bit picks block-addressed SDHC
                        n_found  = i_item.resp_word[30] ? sdid_pkg::CT_SDHC
                                                        : sdid_pkg::CT_SDSC_V2;
                        n_phase  = PH_CMD9;
                        o_result = f_cmd(sdid_pkg::CMD_SEND_CSD, 32'd0,
                                         sdid_pkg::V2_CSD_DUMMY, 1'b0);
                    end
                end
                PH_CMD9: begin
                    n_phase = PH_IDLE;
                    if (!i_item.transport_ok) begin
                        o_result = f_fail(sdid_pkg::ST_XPORT_ERR, r_found);
                    end else if (!s_csd.ok) begin
                        o_result = f_fail(sdid_pkg::ST_FAILED, r_found);
                    end else begin
                        if (s_csd.is_xc) begin
                            n_found = sdid_pkg::CT_SDXC;
                        end
                        o_result                 = f_fail(sdid_pkg::ST_OK, n_found);
                        o_result.num_blocks      = s_csd.num_blocks;
                        o_result.blk_bytes       = s_csd.blk_bytes;
                        o_result.erase_size_log2 = s_csd.erase_size_log2;
                        o_result.capacity_bytes  = s_csd.capacity_bytes;
                    end
                end
                default: begin
                    // idle or unused code: responses are dropped
                    o_has_result = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_retries <= 8'd0;
            r_path_v2 <= 1'b0;
            r_found   <= sdid_pkg::CT_UNKNOWN;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_retries <= n_retries;
            r_path_v2 <= n_path_v2;
            r_found   <= n_found;
        end
    end
endmodule

// ----- hdl/sd_card_identification_sequencer.sv -----
// Top level of the SD card (SPI mode) identification sequencer.
//
// Usage:
//   i_in carries one item per handshake (valid & ready): func = 0 starts an
//   identification, func = 1 delivers the response to the last command sent.
//   o_out returns at most one item per input: either the next command to
//   send (action = 0, with index, argument, dummy bytes and 1 ms delay flag)
//   or a finish item (action = 1, with status, card type and CSD geometry).
//   Responses that arrive while no identification is running give no item.
//   The APB port holds the ACMD41 retry limit at byte address 0.
// Timing:
//   An accepted item lands in an input register; the step logic then runs
//   on it and writes the result register once that register is free. The
//   input register advances whenever the result register is empty or being
//   drained, so one item per cycle is sustained while the receiver keeps
//   ready high.
// Reset (synchronous, active low): no identification in progress, retry
//   limit 255, both registers empty.
// Stall: when o_out.ready is low the result holds, one more item can wait
//   in the input register, and i_in.ready drops until the result is taken.
module sd_card_identification_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sdid_in_if.sink                       i_in,
    sdid_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdid_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    logic              r_in_valid;
    sdid_pkg::t_item   r_in;
    logic              r_out_valid;
    sdid_pkg::t_result r_out;

    logic              s_step;
    logic              s_has_result;
    sdid_pkg::t_result s_result;
    logic [7:0]        s_retry_limit;

    sdid_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_retry_limit (s_retry_limit)
    );

    // step the held item once the result slot is free or freeing up
    assign s_step     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || s_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.func         <= i_in.func;
            r_in.transport_ok <= i_in.transport_ok;
            r_in.r1_byte      <= i_in.r1_byte;
            r_in.resp_word    <= i_in.resp_word;
            r_in.csd_high     <= i_in.csd_high;
            r_in.csd_low      <= i_in.csd_low;
        end
    end

    sdid_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (s_step),
        .i_item        (r_in),
        .i_retry_limit (s_retry_limit),
        .o_has_result  (s_has_result),
        .o_result      (s_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_step) begin
            r_out_valid <= s_has_result;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_step && s_has_result) begin
            r_out <= s_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.action          = r_out.action;
    assign o_out.cmd_index       = r_out.cmd_index;
    assign o_out.cmd_arg         = r_out.cmd_arg;
    assign o_out.dummy_before    = r_out.dummy_before;
    assign o_out.delay_before    = r_out.delay_before;
    assign o_out.status          = r_out.status;
    assign o_out.card_type       = r_out.card_type;
    assign o_out.num_blocks      = r_out.num_blocks;
    assign o_out.blk_bytes       = r_out.blk_bytes;
    assign o_out.erase_size_log2 = r_out.erase_size_log2;
    assign o_out.capacity_bytes  = r_out.capacity_bytes;
endmodule
